>>> src/psd_pkg.sv
// Package for point_segment_distance: shared widths, region codes and the
// queue entry type passed from the classify front to the distance back end.
// No dependencies.
`default_nettype none
package psd_pkg;

  localparam int unsigned CW = 20;                    // coordinate width
  localparam int unsigned DW = 22;                    // distance width
  localparam int unsigned EW = CW + 1;                // endpoint difference width
  localparam int unsigned SW = 2 * EW + 1;            // sum of two squares / cross
  localparam int unsigned TW = 2 * SW;                // cross squared

  typedef enum logic [1:0] {
    RegStart    = 2'd0,
    RegEnd      = 2'd1,
    RegInterior = 2'd2
  } region_e;

  // One classified item: numerator and divisor of the squared distance.
  typedef struct packed {
    logic [TW-1:0] num;   // squared distance times k
    logic [SW-1:0] k;     // 1 for endpoints, |B-A|^2 for interior
    region_e       region;
  } item_t;

endpackage
`default_nettype wire

>>> src/psd_front.sv
// Front end: accepts segment/point beats, classifies the region and forms
// the numerator (squared length or cross^2) and divisor. Uses psd_pkg.
`default_nettype none
module psd_front (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      valid_i,
  output      logic                      ready_o,
  input  wire logic signed [psd_pkg::CW-1:0] ax_i,
  input  wire logic signed [psd_pkg::CW-1:0] ay_i,
  input  wire logic signed [psd_pkg::CW-1:0] bx_i,
  input  wire logic signed [psd_pkg::CW-1:0] by_i,
  input  wire logic signed [psd_pkg::CW-1:0] px_i,
  input  wire logic signed [psd_pkg::CW-1:0] py_i,
  output      logic                      valid_o,
  input  wire logic                      ready_i,
  output      psd_pkg::item_t            item_o
);
  import psd_pkg::*;

  // split of |cross| into a high and a low half for squaring
  localparam int unsigned LW = EW;
  localparam int unsigned HW = SW - EW;

  // stage 1: differences
  logic signed [EW-1:0] abx_q, aby_q, apx_q, apy_q, bpx_q, bpy_q;
  logic                 v1_q;
  // stage 2: products (each at most 21x21)
  logic signed [SW-1:0] dot_a_q, dot_b_q, cross_q, lab_q, lap_q, lbp_q;
  logic                 v2_q;
  // stage 3: classified, partial products of cross squared
  region_e              rg3_q;
  logic [SW-1:0]        len3_q, k3_q;
  logic [2*HW-1:0]      hh_q;
  logic [SW-1:0]        hl_q;
  logic [2*LW-1:0]      ll_q;
  logic                 v3_q;
  // stage 4: queue entry
  item_t                it_q;
  logic                 v4_q;
  logic [SW-1:0]        cmag;
  logic [HW-1:0]        chi;
  logic [LW-1:0]        clo;
  logic                 adv;

  assign adv     = !v4_q || ready_i;
  assign ready_o = adv;
  assign valid_o = v4_q;
  assign item_o  = it_q;
  assign cmag    = cross_q[SW-1] ? SW'(-cross_q) : SW'(cross_q);
  assign chi     = cmag[SW-1:LW];
  assign clo     = cmag[LW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (adv) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      abx_q <= EW'(bx_i) - EW'(ax_i);
      aby_q <= EW'(by_i) - EW'(ay_i);
      apx_q <= EW'(px_i) - EW'(ax_i);
      apy_q <= EW'(py_i) - EW'(ay_i);
      bpx_q <= EW'(px_i) - EW'(bx_i);
      bpy_q <= EW'(py_i) - EW'(by_i);
      // products
      dot_a_q <= SW'(abx_q) * SW'(apx_q) + SW'(aby_q) * SW'(apy_q);
      dot_b_q <= -(SW'(abx_q) * SW'(bpx_q) + SW'(aby_q) * SW'(bpy_q));
      cross_q <= SW'(apx_q) * SW'(bpy_q) - SW'(apy_q) * SW'(bpx_q);
      lab_q   <= SW'(abx_q) * SW'(abx_q) + SW'(aby_q) * SW'(aby_q);
      lap_q   <= SW'(apx_q) * SW'(apx_q) + SW'(apy_q) * SW'(apy_q);
      lbp_q   <= SW'(bpx_q) * SW'(bpx_q) + SW'(bpy_q) * SW'(bpy_q);
      // classify
      if (dot_a_q <= 0) begin
        len3_q <= lap_q;
        k3_q   <= SW'(1);
        rg3_q  <= RegStart;
      end else if (dot_b_q <= 0) begin
        len3_q <= lbp_q;
        k3_q   <= SW'(1);
        rg3_q  <= RegEnd;
      end else begin
        len3_q <= '0;
        k3_q   <= lab_q;
        rg3_q  <= RegInterior;
      end
      hh_q <= (2*HW)'(chi) * (2*HW)'(chi);
      hl_q <= SW'(chi) * SW'(clo);
      ll_q <= (2*LW)'(clo) * (2*LW)'(clo);
      // cross^2 = hh*2^(2L) + 2*hl*2^L + ll
      if (rg3_q == RegInterior) begin
        it_q.num <= (TW'(hh_q) << (2 * LW)) + (TW'(hl_q) << (LW + 1)) + TW'(ll_q);
      end else begin
        it_q.num <= TW'(len3_q);
      end
      it_q.k      <= k3_q;
      it_q.region <= rg3_q;
    end
  end
endmodule
`default_nettype wire

>>> src/psd_queue.sv
// Short skid queue between front and back end. Uses psd_pkg.
`default_nettype none
module psd_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           valid_i,
  output      logic           ready_o,
  input  wire psd_pkg::item_t item_i,
  output      logic           valid_o,
  input  wire logic           ready_i,
  output      psd_pkg::item_t item_o
);
  import psd_pkg::*;

  item_t       mem_q [2];
  logic        wp_q, rp_q;
  logic [1:0]  cnt_q;
  logic        push, pop;

  assign ready_o = cnt_q != 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign item_o  = mem_q[rp_q];
  assign push    = valid_i && ready_o;
  assign pop     = valid_o && ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= !wp_q;
      if (pop)  rp_q <= !rp_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= item_i;
  end
endmodule
`default_nettype wire

>>> src/psd_back.sv
// Back end: pipelined restoring root search, one result bit per stage:
// largest d with d*d*k <= num. Uses psd_pkg.
`default_nettype none
module psd_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           valid_i,
  output      logic           ready_o,
  input  wire psd_pkg::item_t item_i,
  output      logic           valid_o,
  input  wire logic           ready_i,
  output      logic [psd_pkg::DW-1:0] dist_o,
  output      psd_pkg::region_e region_o
);
  import psd_pkg::*;

  // per stage: remainder num - d^2*k kept with d*k so the test is
  // rem >= (2*d*2^b + 4^b)*k, all shifts plus one add and compare
  localparam int unsigned RW = TW + 1;
  logic [RW-1:0]       rem_q [DW+1];
  logic [RW-1:0]       dk_q  [DW+1];   // d*k
  logic [SW-1:0]       k_q   [DW+1];
  logic [DW-1:0]       d_q   [DW+1];
  region_e             rg_q  [DW+1];
  logic [DW:0]         v_q;
  logic                adv;

  assign adv      = !v_q[DW] || ready_i;
  assign ready_o  = adv;
  assign valid_o  = v_q[DW];
  assign dist_o   = d_q[DW];
  assign region_o = rg_q[DW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_q <= '0;
    else if (adv) v_q <= {v_q[DW-1:0], valid_i};
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rem_q[0] <= RW'(item_i.num);
      dk_q[0]  <= '0;
      k_q[0]   <= item_i.k;
      d_q[0]   <= '0;
      rg_q[0]  <= item_i.region;
    end
  end

  for (genvar s = 0; s < DW; s++) begin : g_stage
    localparam int unsigned B = DW - 1 - s;
    logic [RW+2*DW-1:0] need;
    // (2*d*k << B) + (k << 2B); wide enough that nothing wraps
    assign need = ((RW+2*DW)'(dk_q[s]) << (B + 1)) + ((RW+2*DW)'(k_q[s]) << (2 * B));
    always_ff @(posedge clk_i) begin
      if (adv) begin
        k_q[s+1]  <= k_q[s];
        rg_q[s+1] <= rg_q[s];
        if ((RW+2*DW)'(rem_q[s]) >= need) begin
          rem_q[s+1] <= RW'((RW+2*DW)'(rem_q[s]) - need);
          dk_q[s+1]  <= dk_q[s] + (RW'(k_q[s]) << B);
          d_q[s+1]   <= d_q[s] | (DW'(1) << B);
        end else begin
          rem_q[s+1] <= rem_q[s];
          dk_q[s+1]  <= dk_q[s];
          d_q[s+1]   <= d_q[s];
        end
      end
    end
  end
endmodule
`default_nettype wire

>>> src/point_segment_distance.sv
// Top level of point_segment_distance: front classifier, skid queue and
// root back end. Uses psd_pkg, psd_front, psd_queue, psd_back.
//
// Use: one beat on the input channel carries segment A-B and point P
// (signed Q12.8). One beat on the output channel carries the floor of
// the distance (Q14.8) and the region (start, end, interior).
// Throughput: one beat per cycle when the receiver keeps ready high.
// Path: the front registers differences, products, classification,
// the queue entry, then the queue store, then the root pipeline: an
// input register and the one-bit-per-stage root search over the 22 result bits.
// Reset (rst_ni low, asynchronous) empties every stage and the queue.
// When the receiver stalls, the back pipeline holds, the 2-entry queue
// fills, and then the front stops taking beats; nothing is dropped.
`default_nettype none
module point_segment_distance (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output      logic in_ready_o,
  input  wire logic signed [19:0] seg_a_x_i,
  input  wire logic signed [19:0] seg_a_y_i,
  input  wire logic signed [19:0] seg_b_x_i,
  input  wire logic signed [19:0] seg_b_y_i,
  input  wire logic signed [19:0] point_x_i,
  input  wire logic signed [19:0] point_y_i,
  output      logic out_valid_o,
  input  wire logic out_ready_i,
  output      logic [21:0] distance_o,
  output      logic [1:0]  nearest_region_o
);
  import psd_pkg::*;

  item_t   f_item, q_item;
  logic    f_valid, f_ready, q_valid, q_ready;
  region_e region;

  psd_front u_front (
    .clk_i, .rst_ni,
    .valid_i(in_valid_i), .ready_o(in_ready_o),
    .ax_i(seg_a_x_i), .ay_i(seg_a_y_i), .bx_i(seg_b_x_i), .by_i(seg_b_y_i),
    .px_i(point_x_i), .py_i(point_y_i),
    .valid_o(f_valid), .ready_i(f_ready), .item_o(f_item)
  );

  psd_queue u_queue (
    .clk_i, .rst_ni,
    .valid_i(f_valid), .ready_o(f_ready), .item_i(f_item),
    .valid_o(q_valid), .ready_i(q_ready), .item_o(q_item)
  );

  psd_back u_back (
    .clk_i, .rst_ni,
    .valid_i(q_valid), .ready_o(q_ready), .item_i(q_item),
    .valid_o(out_valid_o), .ready_i(out_ready_i),
    .dist_o(distance_o), .region_o(region)
  );

  assign nearest_region_o = region;
endmodule
`default_nettype wire
